[rtl/rv32i_decode_forward_macros.svh]
// Assertion macros used by the checker module of the decode stage.
`ifndef RV32I_DECODE_FORWARD_MACROS_SVH
`define RV32I_DECODE_FORWARD_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define RVDF_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("decode stage check failed");

// Next-cycle implication, disabled while in reset.
`define RVDF_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("decode stage check failed");

`endif

[rtl/rvdf_pkg.sv]
// Package with opcodes, format codes and transaction types of the decode stage.
package rvdf_pkg;

  // Major opcodes
  localparam logic [6:0] OP_LUI    = 7'b0110111;
  localparam logic [6:0] OP_AUIPC  = 7'b0010111;
  localparam logic [6:0] OP_JAL    = 7'b1101111;
  localparam logic [6:0] OP_JALR   = 7'b1100111;
  localparam logic [6:0] OP_LOAD   = 7'b0000011;
  localparam logic [6:0] OP_OPIMM  = 7'b0010011;
  localparam logic [6:0] OP_BRANCH = 7'b1100011;
  localparam logic [6:0] OP_STORE  = 7'b0100011;
  localparam logic [6:0] OP_OP     = 7'b0110011;

  // Instruction format codes
  typedef enum logic [2:0] {
    FMT_NONE = 3'd0,
    FMT_U    = 3'd1,
    FMT_J    = 3'd2,
    FMT_I    = 3'd3,
    FMT_B    = 3'd4,
    FMT_S    = 3'd5,
    FMT_R    = 3'd6
  } fmt_t;

  // Input transaction
  typedef struct packed {
    logic [31:0] instr;
    logic [31:0] pc;
    logic [31:0] rf_val1;
    logic [31:0] rf_val2;
    logic [4:0]  exe_dest;
    logic [6:0]  exe_op;
    logic [31:0] exe_value;
    logic [4:0]  mem_dest;
    logic [6:0]  mem_op;
    logic [31:0] mem_value;
  } in_item_t;

  // Result transaction
  typedef struct packed {
    logic [2:0]         format;
    logic [6:0]         opcode_out;
    logic [2:0]         funct3_out;
    logic [6:0]         funct7_out;
    logic [4:0]         dest_reg;
    logic [4:0]         src1_reg;
    logic [4:0]         src2_reg;
    logic signed [31:0] immediate;
    logic [31:0]        operand1;
    logic [31:0]        operand2;
    logic               redirect;
    logic [31:0]        target;
  } out_item_t;

  // Decoder output toward the operand and target logic
  typedef struct packed {
    fmt_t        fmt;
    logic [2:0]  funct3;
    logic [6:0]  funct7;
    logic [4:0]  rd;
    logic [4:0]  rs1;
    logic [4:0]  rs2;
    logic [31:0] imm;
    logic        has_rs1;
    logic        has_rs2;
    logic        is_jal;
    logic        is_jalr;
  } dec_t;

  // Bypass sources from the later pipeline stages
  typedef struct packed {
    logic [4:0]  exe_dest;
    logic [6:0]  exe_op;
    logic [31:0] exe_value;
    logic [4:0]  mem_dest;
    logic [6:0]  mem_op;
    logic [31:0] mem_value;
  } byp_t;

endpackage

[rtl/rvdf_decode.sv]
// Instruction decoder: format, register fields and sign-extended immediate.
module rvdf_decode (
  input  logic [31:0]   instr,
  output rvdf_pkg::dec_t dec
);
  import rvdf_pkg::*;

  logic [6:0] op;

  assign op = instr[6:0];

  // Decode fields per format; fields a format lacks stay zero
  always_comb begin
    dec = '0;
    dec.fmt = FMT_NONE;
    unique case (op) inside
      OP_LUI, OP_AUIPC: begin
        dec.fmt = FMT_U;
        dec.rd  = instr[11:7];
        dec.imm = {instr[31:12], 12'b0};
      end
      OP_JAL: begin
        dec.fmt    = FMT_J;
        dec.rd     = instr[11:7];
        dec.imm    = {{11{instr[31]}}, instr[31], instr[19:12], instr[20],
                      instr[30:21], 1'b0};
        dec.is_jal = 1'b1;
      end
      OP_JALR, OP_LOAD, OP_OPIMM: begin
        dec.fmt     = FMT_I;
        dec.rd      = instr[11:7];
        dec.funct3  = instr[14:12];
        dec.rs1     = instr[19:15];
        dec.has_rs1 = 1'b1;
        dec.imm     = {{20{instr[31]}}, instr[31:20]};
        dec.is_jalr = (op == OP_JALR);
      end
      OP_BRANCH: begin
        dec.fmt     = FMT_B;
        dec.funct3  = instr[14:12];
        dec.rs1     = instr[19:15];
        dec.rs2     = instr[24:20];
        dec.has_rs1 = 1'b1;
        dec.has_rs2 = 1'b1;
        dec.imm     = {{19{instr[31]}}, instr[31], instr[7], instr[30:25],
                       instr[11:8], 1'b0};
      end
      OP_STORE: begin
        dec.fmt     = FMT_S;
        dec.funct3  = instr[14:12];
        dec.rs1     = instr[19:15];
        dec.rs2     = instr[24:20];
        dec.has_rs1 = 1'b1;
        dec.has_rs2 = 1'b1;
        dec.imm     = {{20{instr[31]}}, instr[31:25], instr[11:7]};
      end
      OP_OP: begin
        dec.fmt     = FMT_R;
        dec.rd      = instr[11:7];
        dec.funct3  = instr[14:12];
        dec.funct7  = instr[31:25];
        dec.rs1     = instr[19:15];
        dec.rs2     = instr[24:20];
        dec.has_rs1 = 1'b1;
        dec.has_rs2 = 1'b1;
      end
      default: begin
        dec = '0;
      end
    endcase
  end

endmodule

[rtl/rvdf_fwd.sv]
// Operand bypass mux for one source register.
module rvdf_fwd (
  input  logic [4:0]     src_idx,
  input  logic [31:0]    rf_val,
  input  rvdf_pkg::byp_t byp,
  output logic [31:0]    operand
);
  import rvdf_pkg::*;

  logic exe_hit;
  logic mem_hit;

  // Branches and stores write no register, so they never match
  assign exe_hit = (src_idx == byp.exe_dest) &&
                   (byp.exe_op != OP_BRANCH) && (byp.exe_op != OP_STORE);
  assign mem_hit = (src_idx == byp.mem_dest) &&
                   (byp.mem_op != OP_BRANCH) && (byp.mem_op != OP_STORE);

  // Pick EXE first, then MEM; a load in EXE keeps the register file value
  always_comb begin
    if (src_idx == 5'd0) begin
      operand = rf_val;
    end else if (exe_hit) begin
      operand = (byp.exe_op == OP_LOAD) ? rf_val : byp.exe_value;
    end else if (mem_hit) begin
      operand = byp.mem_value;
    end else begin
      operand = rf_val;
    end
  end

endmodule

[rtl/rv32i_decode_forward.sv]
// Top level of the RV32I decode stage with operand forwarding.
//
// Input channel in_valid/in_stall/in_data carries one instruction with its
// PC, register file reads and the EXE and MEM bypass sources. Output channel
// out_valid/out_stall/out_data carries the decoded fields, forwarded
// operands and the jump redirect. A transaction moves at a rising edge where
// valid is high and stall is low.
//
// Two register stages: an input register and a result register, with the
// decoder, bypass muxes and the target adder between them. A transaction
// passes the input register, then the result register, to the output;
// throughput is one transaction per cycle while out_stall is low. The
// input register refills while the result register is being drained.
//
// Reset (rst_n low, synchronous) empties both stages. When the receiver
// stalls, the result register holds its transaction; a second transaction
// waits in the input register, and only then is in_stall raised.
module rv32i_decode_forward (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  rvdf_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output rvdf_pkg::out_item_t out_data
);
  import rvdf_pkg::*;

  logic        s1_valid_r;
  logic        s1_valid_nxt;
  in_item_t    s1_data_r;
  logic        out_valid_r;
  logic        out_valid_nxt;
  out_item_t   out_data_r;
  out_item_t   res_nxt;
  logic        in_acc;
  logic        s1_adv;
  logic        out_acc;
  dec_t        dec;
  byp_t        byp;
  logic [31:0] fwd1;
  logic [31:0] fwd2;
  logic [31:0] opnd1;
  logic [31:0] opnd2;
  logic [31:0] tgt_base;
  logic [31:0] tgt_sum;

  // Handshake
  assign out_acc   = out_valid_r && !out_stall;
  assign s1_adv    = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall  = s1_valid_r && out_valid_r && out_stall;
  assign in_acc    = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Decode the held instruction
  rvdf_decode u_decode (
    .instr (s1_data_r.instr),
    .dec   (dec)
  );

  assign byp.exe_dest  = s1_data_r.exe_dest;
  assign byp.exe_op    = s1_data_r.exe_op;
  assign byp.exe_value = s1_data_r.exe_value;
  assign byp.mem_dest  = s1_data_r.mem_dest;
  assign byp.mem_op    = s1_data_r.mem_op;
  assign byp.mem_value = s1_data_r.mem_value;

  // Forward both source operands
  rvdf_fwd u_fwd1 (
    .src_idx (dec.rs1),
    .rf_val  (s1_data_r.rf_val1),
    .byp     (byp),
    .operand (fwd1)
  );

  rvdf_fwd u_fwd2 (
    .src_idx (dec.rs2),
    .rf_val  (s1_data_r.rf_val2),
    .byp     (byp),
    .operand (fwd2)
  );

  assign opnd1 = dec.has_rs1 ? fwd1 : 32'd0;
  assign opnd2 = dec.has_rs2 ? fwd2 : 32'd0;

  // Jump target: PC-relative for JAL, register-relative for JALR
  assign tgt_base = dec.is_jalr ? opnd1 : s1_data_r.pc;
  assign tgt_sum  = tgt_base + dec.imm;

  // Assemble the result transaction
  always_comb begin
    res_nxt            = '0;
    res_nxt.format     = dec.fmt;
    res_nxt.opcode_out = s1_data_r.instr[6:0];
    res_nxt.funct3_out = dec.funct3;
    res_nxt.funct7_out = dec.funct7;
    res_nxt.dest_reg   = dec.rd;
    res_nxt.src1_reg   = dec.rs1;
    res_nxt.src2_reg   = dec.rs2;
    res_nxt.immediate  = signed'(dec.imm);
    res_nxt.operand1   = opnd1;
    res_nxt.operand2   = opnd2;
    res_nxt.redirect   = dec.is_jal || dec.is_jalr;
    if (dec.is_jalr) begin
      res_nxt.target = {tgt_sum[31:1], 1'b0};
    end else if (dec.is_jal) begin
      res_nxt.target = tgt_sum;
    end else begin
      res_nxt.target = 32'd0;
    end
  end

  // Next valid flags: fill on accept, drain on advance
  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_acc) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_adv) begin
      s1_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (s1_adv) begin
      out_valid_nxt = 1'b1;
    end else if (out_acc) begin
      out_valid_nxt = 1'b0;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers: load on transaction, hold otherwise
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_data_r <= in_data;
    end
    if (s1_adv) begin
      out_data_r <= res_nxt;
    end
  end

endmodule

[rtl/rvdf_checker.sv]
// Port-level checker for the decode stage and its bind to the top level.
`include "rv32i_decode_forward_macros.svh"

module rvdf_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_stall,
  input logic                out_valid,
  input logic                out_stall,
  input rvdf_pkg::out_item_t out_data
);
  import rvdf_pkg::*;

  logic jump_op;

  // Flag the jump opcodes on the output
  assign jump_op = (out_data.opcode_out == OP_JAL) || (out_data.opcode_out == OP_JALR);

  // A stalled result holds
  `RVDF_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data))
  // Input backs up only behind a stalled, full output
  `RVDF_ASSERT_NOW(a_stall_cause, in_stall, out_valid && out_stall)
  // An accepted transaction reaches the output via the input register without stall
  `RVDF_ASSERT_NEXT(a_latency, (in_valid && !in_stall) ##1 !out_stall, out_valid)
  // Only jumps redirect
  `RVDF_ASSERT_NOW(a_redirect_op, out_valid && out_data.redirect, jump_op)

endmodule

bind rv32i_decode_forward rvdf_checker u_rvdf_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

[tb/rv32i_decode_forward_checker.sv]
// Checker that predicts the decode stage results and compares them on the output channel.
module rv32i_decode_forward_checker (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_stall,
  input  rvdf_pkg::in_item_t  in_data,
  input  logic                out_valid,
  input  logic                out_stall,
  input  rvdf_pkg::out_item_t out_data,
  output int                  mismatch_count,
  output int                  outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  import rvdf_pkg::*;

  // Decoded results still owed by the stage, oldest first
  out_item_t pending_decodes[$];
  out_item_t oldest;
  int        result_idx = 0;
  int        fail_count = 0;
  int        owed_count = 0;

  assign mismatch_count = fail_count;
  assign outstanding    = owed_count;

  // Pick a source operand: register file, EXE bypass or MEM bypass
  function automatic logic [31:0] bypass_operand(logic [4:0] src, logic [31:0] rf_val,
                                                 in_item_t t);
    if (src == 5'd0)
      return rf_val;
    if (src == t.exe_dest && t.exe_op != OP_BRANCH && t.exe_op != OP_STORE)
      return (t.exe_op == OP_LOAD) ? rf_val : t.exe_value;
    if (src == t.mem_dest && t.mem_op != OP_BRANCH && t.mem_op != OP_STORE)
      return t.mem_value;
    return rf_val;
  endfunction

  // Decode one instruction into the result the stage must give
  function automatic out_item_t decode_instr(in_item_t t);
    out_item_t   r;
    logic [31:0] ins;
    logic        use1;
    logic        use2;
    ins  = t.instr;
    r    = '0;
    use1 = 1'b0;
    use2 = 1'b0;
    r.opcode_out = ins[6:0];
    case (ins[6:0]) inside
      OP_LUI, OP_AUIPC: begin
        r.format    = FMT_U;
        r.dest_reg  = ins[11:7];
        r.immediate = {ins[31:12], 12'b0};
      end
      OP_JAL: begin
        r.format    = FMT_J;
        r.dest_reg  = ins[11:7];
        r.immediate = {{11{ins[31]}}, ins[31], ins[19:12], ins[20], ins[30:21], 1'b0};
        r.redirect  = 1'b1;
        r.target    = t.pc + $unsigned(r.immediate);
      end
      OP_JALR, OP_LOAD, OP_OPIMM: begin
        r.format     = FMT_I;
        r.dest_reg   = ins[11:7];
        r.funct3_out = ins[14:12];
        r.src1_reg   = ins[19:15];
        r.immediate  = {{20{ins[31]}}, ins[31:20]};
        use1         = 1'b1;
      end
      OP_BRANCH: begin
        r.format     = FMT_B;
        r.funct3_out = ins[14:12];
        r.src1_reg   = ins[19:15];
        r.src2_reg   = ins[24:20];
        r.immediate  = {{19{ins[31]}}, ins[31], ins[7], ins[30:25], ins[11:8], 1'b0};
        use1         = 1'b1;
        use2         = 1'b1;
      end
      OP_STORE: begin
        r.format     = FMT_S;
        r.funct3_out = ins[14:12];
        r.src1_reg   = ins[19:15];
        r.src2_reg   = ins[24:20];
        r.immediate  = {{20{ins[31]}}, ins[31:25], ins[11:7]};
        use1         = 1'b1;
        use2         = 1'b1;
      end
      OP_OP: begin
        r.format     = FMT_R;
        r.dest_reg   = ins[11:7];
        r.funct3_out = ins[14:12];
        r.funct7_out = ins[31:25];
        r.src1_reg   = ins[19:15];
        r.src2_reg   = ins[24:20];
        use1         = 1'b1;
        use2         = 1'b1;
      end
      default: ;
    endcase
    if (use1)
      r.operand1 = bypass_operand(ins[19:15], t.rf_val1, t);
    if (use2)
      r.operand2 = bypass_operand(ins[24:20], t.rf_val2, t);
    // JALR jumps to rs1 plus offset with the low bit dropped
    if (ins[6:0] == OP_JALR) begin
      r.redirect = 1'b1;
      r.target   = (r.operand1 + $unsigned(r.immediate)) & ~32'd1;
    end
    return r;
  endfunction

  task automatic report_mismatch(string msg);
    $display("[%0t] decode mismatch: %s", $time, msg);
    fail_count++;
  endtask

  task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
    if (got !== want)
      report_mismatch($sformatf("result %0d %s: got %h, want %h", result_idx, name, got, want));
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      pending_decodes.delete();
    end else begin
      // queue a prediction for each accepted instruction
      if (in_valid && !in_stall)
        pending_decodes.push_back(decode_instr(in_data));
      // compare each accepted result with the oldest prediction
      if (out_valid && !out_stall) begin
        if (pending_decodes.size() == 0) begin
          report_mismatch($sformatf("result %0d arrived with nothing outstanding", result_idx));
        end else begin
          oldest = pending_decodes.pop_front();
          check_field("format", out_data.format, oldest.format);
          check_field("opcode_out", out_data.opcode_out, oldest.opcode_out);
          check_field("funct3_out", out_data.funct3_out, oldest.funct3_out);
          check_field("funct7_out", out_data.funct7_out, oldest.funct7_out);
          check_field("dest_reg", out_data.dest_reg, oldest.dest_reg);
          check_field("src1_reg", out_data.src1_reg, oldest.src1_reg);
          check_field("src2_reg", out_data.src2_reg, oldest.src2_reg);
          check_field("immediate", out_data.immediate, oldest.immediate);
          check_field("operand1", out_data.operand1, oldest.operand1);
          check_field("operand2", out_data.operand2, oldest.operand2);
          check_field("redirect", out_data.redirect, oldest.redirect);
          check_field("target", out_data.target, oldest.target);
        end
        result_idx++;
      end
    end
    owed_count = pending_decodes.size();
  end

endmodule

[tb/rv32i_decode_forward_tb.sv]
// Testbench top: drives instructions into the decode stage and gives the verdict.
module rv32i_decode_forward_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import rvdf_pkg::*;

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_stall;
  in_item_t  in_data   = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;

  int mismatch_count;
  int outstanding;
  int send_idle_pct  = 37;
  int recv_stall_pct = 70;

  rv32i_decode_forward dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  rv32i_decode_forward_checker decode_chk (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_data        (in_data),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_data       (out_data),
    .mismatch_count (mismatch_count),
    .outstanding    (outstanding)
  );

  always #4 clk = ~clk;

  // Stall the result channel at random
  always @(posedge clk) begin
    out_stall <= rst_n && ($urandom_range(99) < recv_stall_pct);
  end

  // Offer one instruction, idling first at random, and hold it until taken
  task automatic send_instr(in_item_t item);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (in_stall !== 1'b0);
  endtask

  function automatic logic [31:0] rv_word(logic [6:0] f7, logic [4:0] rs2, logic [4:0] rs1,
                                          logic [2:0] f3, logic [4:0] rd, logic [6:0] op);
    return {f7, rs2, rs1, f3, rd, op};
  endfunction

  // Directed transaction with distinct register file and bypass values
  function automatic in_item_t stage_item(logic [31:0] instr, logic [31:0] pc,
                                          logic [4:0] ed, logic [6:0] eo,
                                          logic [4:0] md, logic [6:0] mo);
    in_item_t t;
    t.instr     = instr;
    t.pc        = pc;
    t.rf_val1   = 32'h1111_1111;
    t.rf_val2   = 32'h2222_2222;
    t.exe_dest  = ed;
    t.exe_op    = eo;
    t.exe_value = 32'hEEEE_0001;
    t.mem_dest  = md;
    t.mem_op    = mo;
    t.mem_value = 32'hAAAA_0002;
    return t;
  endfunction

  // Opcode of an instruction sitting in a later stage
  function automatic logic [6:0] stage_op();
    case ($urandom_range(0, 7))
      0:       return OP_LOAD;
      1:       return OP_BRANCH;
      2:       return OP_STORE;
      3:       return OP_OPIMM;
      4:       return OP_OP;
      5:       return OP_JAL;
      6:       return OP_LUI;
      default: return 7'($urandom);
    endcase
  endfunction

  // Bypass destination: rs1, rs2, register zero or a random index
  function automatic logic [4:0] stage_dest(logic [4:0] rs1, logic [4:0] rs2);
    case ($urandom_range(0, 3))
      0:       return rs1;
      1:       return rs2;
      2:       return 5'd0;
      default: return 5'($urandom);
    endcase
  endfunction

  // Mostly valid opcodes with random fields; the rest unknown opcodes
  function automatic in_item_t random_instr();
    in_item_t   t;
    logic [6:0] op;
    case ($urandom_range(0, 10))
      0:       op = OP_LUI;
      1:       op = OP_AUIPC;
      2:       op = OP_JAL;
      3:       op = OP_JALR;
      4:       op = OP_LOAD;
      5:       op = OP_OPIMM;
      6:       op = OP_BRANCH;
      7:       op = OP_STORE;
      8:       op = OP_OP;
      default: op = 7'($urandom);
    endcase
    t.instr      = $urandom;
    t.instr[6:0] = op;
    if ($urandom_range(0, 7) == 0)
      t.instr[19:15] = 5'd0;
    if ($urandom_range(0, 7) == 0)
      t.instr[24:20] = 5'd0;
    t.pc        = $urandom;
    t.rf_val1   = $urandom;
    t.rf_val2   = $urandom;
    t.exe_dest  = stage_dest(t.instr[19:15], t.instr[24:20]);
    t.exe_op    = stage_op();
    t.exe_value = $urandom;
    t.mem_dest  = stage_dest(t.instr[19:15], t.instr[24:20]);
    t.mem_op    = stage_op();
    t.mem_value = $urandom;
    return t;
  endfunction

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Field extremes and unknown opcodes
    send_instr('0);
    send_instr('1);
    send_instr(stage_item(rv_word(7'h7F, 5'h1F, 5'h1F, 3'h7, 5'h1F, OP_LUI), 32'h0,
                          5'd0, OP_OP, 5'd0, OP_OP));
    // AUIPC decodes as U and does not redirect
    send_instr(stage_item(rv_word(7'h12, 5'h03, 5'h04, 3'h5, 5'h06, OP_AUIPC), 32'h1000,
                          5'd4, OP_OP, 5'd3, OP_OP));
    // JAL targets wrapping below zero and past the top
    send_instr(stage_item(rv_word(7'h7F, 5'h1F, 5'h1F, 3'h7, 5'h01, OP_JAL), 32'h0,
                          5'd1, OP_OP, 5'd1, OP_OP));
    send_instr(stage_item(rv_word(7'h3F, 5'h1F, 5'h1F, 3'h7, 5'h01, OP_JAL), 32'hFFFF_FFF0,
                          5'd0, OP_OP, 5'd0, OP_OP));
    // JALR with an odd sum, then with a forwarded base and negative offset
    send_instr(stage_item(rv_word(7'h00, 5'h00, 5'h05, 3'h0, 5'h01, OP_JALR), 32'h40,
                          5'd0, OP_OP, 5'd0, OP_OP));
    send_instr(stage_item(rv_word(7'h7F, 5'h1F, 5'h05, 3'h0, 5'h01, OP_JALR), 32'h40,
                          5'd5, OP_OP, 5'd5, OP_OPIMM));
    // Load in EXE keeps the register file value and hides the MEM match
    send_instr(stage_item(rv_word(7'h00, 5'h00, 5'h07, 3'h2, 5'h08, OP_LOAD), 32'h80,
                          5'd7, OP_LOAD, 5'd7, OP_OPIMM));
    // Branch in EXE does not forward, MEM does
    send_instr(stage_item(rv_word(7'h40, 5'h01, 5'h09, 3'h5, 5'h03, OP_OPIMM), 32'h84,
                          5'd9, OP_BRANCH, 5'd9, OP_OPIMM));
    // Store in EXE does not forward, load in MEM does
    send_instr(stage_item(rv_word(7'h7F, 5'h04, 5'h03, 3'h1, 5'h1F, OP_BRANCH), 32'h88,
                          5'd3, OP_STORE, 5'd3, OP_LOAD));
    send_instr(stage_item(rv_word(7'h3F, 5'h04, 5'h03, 3'h0, 5'h1E, OP_BRANCH), 32'h8C,
                          5'd4, OP_JAL, 5'd0, OP_OP));
    // Register zero never forwards
    send_instr(stage_item(rv_word(7'h7F, 5'h06, 5'h00, 3'h2, 5'h1F, OP_STORE), 32'h90,
                          5'd0, OP_OP, 5'd0, OP_OP));
    // Branch in MEM does not forward
    send_instr(stage_item(rv_word(7'h25, 5'h06, 5'h02, 3'h0, 5'h0A, OP_STORE), 32'h94,
                          5'd1, OP_OP, 5'd6, OP_BRANCH));
    // EXE wins over MEM on both sources
    send_instr(stage_item(rv_word(7'h20, 5'h0A, 5'h0A, 3'h0, 5'h0B, OP_OP), 32'h98,
                          5'd10, OP_OP, 5'd10, OP_OP));
    // Store in MEM does not forward; EXE forwards on the other source
    send_instr(stage_item(rv_word(7'h7F, 5'h0D, 5'h0C, 3'h7, 5'h1F, OP_OP), 32'h9C,
                          5'd13, OP_LUI, 5'd12, OP_STORE));
    send_instr(stage_item(rv_word(7'h00, 5'h00, 5'h00, 3'h0, 5'h00, OP_OP), 32'hA0,
                          5'd0, OP_OP, 5'd0, OP_OP));
    // Unknown opcode with live bypass matches
    send_instr(stage_item(rv_word(7'h55, 5'h01, 5'h01, 3'h3, 5'h01, 7'h0B), 32'hA4,
                          5'd1, OP_OP, 5'd1, OP_OP));

    // Random traffic across three idling mixes
    for (int i = 0; i < 170; i++)
      send_instr(random_instr());
    send_idle_pct  = 70;
    recv_stall_pct = 37;
    for (int i = 0; i < 170; i++)
      send_instr(random_instr());
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    for (int i = 0; i < 160; i++)
      send_instr(random_instr());
    in_valid <= 1'b0;

    // Drain, then allow the pipeline latency to settle
    while (outstanding != 0)
      @(negedge clk);
    repeat (10) @(posedge clk);
    @(negedge clk);
    if (mismatch_count == 0 && outstanding == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

  // Abort a hung run
  initial begin
    #1_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

[files.f]
+incdir+rtl
rtl/rvdf_pkg.sv
rtl/rvdf_decode.sv
rtl/rvdf_fwd.sv
rtl/rv32i_decode_forward.sv
rtl/rvdf_checker.sv
tb/rv32i_decode_forward_checker.sv
tb/rv32i_decode_forward_tb.sv
